// File: src/keyed_rotating_sbox_byte_cipher_core_assert.svh
// assertion macros for the keyed rotating s-box cipher core
// expects i_clk and i_rst_n in the scope that uses them
`ifndef KEYED_ROTATING_SBOX_BYTE_CIPHER_CORE_ASSERT_SVH
`define KEYED_ROTATING_SBOX_BYTE_CIPHER_CORE_ASSERT_SVH

// same-cycle implication
`define KRSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/krsc_pkg.sv
// shared types and constants of the keyed rotating s-box cipher core
// no dependencies
`default_nettype none

package krsc_pkg;

    localparam int DATA_W        = 8;
    localparam int BOX_DEPTH     = 256;
    localparam int BOX_AW        = 8;
    localparam int KCNT_W        = 9;
    localparam int KEY_BYTES_DEF = 256;

    // request kind carried in tuser on the input side
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    // decrypt_mode register values
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef enum logic [2:0] {
        SCH_IDLE,
        SCH_INIT,
        SCH_RD_I,
        SCH_RD_J,
        SCH_WR_I,
        SCH_WR_J,
        SCH_INV_RD,
        SCH_INV_WR
    } t_sched_state;

    // access request to the forward and inverse box memories
    typedef struct packed {
        logic              fwd_re;
        logic [BOX_AW-1:0] fwd_raddr;
        logic              fwd_we;
        logic [BOX_AW-1:0] fwd_waddr;
        logic [DATA_W-1:0] fwd_wdata;
        logic              inv_re;
        logic [BOX_AW-1:0] inv_raddr;
        logic              inv_we;
        logic [BOX_AW-1:0] inv_waddr;
        logic [DATA_W-1:0] inv_wdata;
    } t_box_req;

endpackage

`default_nettype wire

// File: src/keyed_rotating_sbox_byte_cipher_core.sv
// top level of the keyed rotating s-box byte cipher
// depends on krsc_pkg, krsc_key_mem, krsc_box_mem, krsc_sched and the assert header
//
// usage
// - input stream: tuser = 0 loads a key byte (tdata), tuser = 1 ciphers a data
//   byte (tdata); tlast on a key byte ends the key and starts the key schedule
// - output stream: one request per data byte, tdata = ciphered byte,
//   tuser = 1 while no key schedule has completed yet; key bytes give nothing
// - cfg channel writes decrypt_mode (0 encrypt, 1 decrypt), always ready;
//   write it only while the core is idle
// - data bytes: one per cycle while s_axis_tready is high; the result passes
//   through the box memory read register, then the output register
// - key bytes: one per cycle while s_axis_tready is high; the final key byte
//   launches the schedule, which holds s_axis_tready low throughout: 256 identity
//   writes, then 256 swap iterations (read i, read j, write i, write j) on the
//   forward box, then 256 inverse writes (read, then write); the read stage is always
//   empty once the schedule starts, so its length does not depend on the output side
// - reset: boxes read as identity, position 0, key empty, encrypt mode
// - receiver stall: one result sits in the output register and one more in
//   the read stage; after that s_axis_tready drops until m_axis_tready returns
`default_nettype none

module keyed_rotating_sbox_byte_cipher_core #(
    parameter int KEY_BYTES = krsc_pkg::KEY_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
    input  wire logic [0:0]  s_axis_tuser,   // [0] action
    input  wire logic        s_axis_tlast,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [0:0]       m_axis_tuser,   // [0] no_key
    // mode register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    localparam int KA_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // handshake decode
    logic w_s_fire, w_data_fire, w_key_fire, w_start, w_adv;
    logic w_busy, w_done;

    // control state
    logic                        r_decrypt;
    logic                        r_keyed;
    logic [krsc_pkg::BOX_AW-1:0] r_pos;

    // read stage: data byte whose box lookup is in flight
    logic                        r_p1_valid;
    logic                        r_p1_dec;
    logic                        r_p1_keyed;
    logic [krsc_pkg::DATA_W-1:0] r_p1_pos;
    logic [krsc_pkg::DATA_W-1:0] r_p1_idx;

    // output register
    logic                        r_out_valid;
    logic [krsc_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_nokey;

    logic [krsc_pkg::BOX_AW-1:0] w_enc_addr;
    logic [krsc_pkg::DATA_W-1:0] w_box_val, w_lookup, n_out_data;
    logic [krsc_pkg::DATA_W-1:0] w_fwd_rdata, w_inv_rdata, w_key_rdata;
    logic [krsc_pkg::KCNT_W-1:0] w_key_count;
    logic                        w_key_re;
    logic [KA_W-1:0]             w_key_raddr;

    krsc_pkg::t_box_req w_sched_req, w_data_req, w_box_req;

    assign w_s_fire    = s_axis_tvalid && s_axis_tready;
    assign w_data_fire = w_s_fire && (s_axis_tuser[0] == krsc_pkg::ACT_DATA);
    assign w_key_fire  = w_s_fire && (s_axis_tuser[0] == krsc_pkg::ACT_KEY);
    assign w_start     = w_key_fire && s_axis_tlast;

    // output register empties or is taken this cycle
    assign w_adv = !r_out_valid || m_axis_tready;

    // no input during the schedule; a parked read stage blocks until it can move
    assign s_axis_tready = !w_busy && (!r_p1_valid || w_adv);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= krsc_pkg::MODE_ENC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decrypt <= i_cfg_data;
        end
    end

    // position advances per data byte and restarts with every new key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_keyed <= 1'b0;
        end else if (w_done) begin
            r_pos   <= '0;
            r_keyed <= 1'b1;
        end else if (w_data_fire) begin
            r_pos   <= r_pos + krsc_pkg::BOX_AW'(1);
        end
    end

    // encrypt reads forward box at value + position, decrypt reads inverse box at value
    assign w_enc_addr = s_axis_tdata + r_pos;

    always_comb begin
        w_data_req           = '0;
        w_data_req.fwd_re    = w_data_fire && (r_decrypt == krsc_pkg::MODE_ENC);
        w_data_req.fwd_raddr = w_enc_addr;
        w_data_req.inv_re    = w_data_fire && (r_decrypt == krsc_pkg::MODE_DEC);
        w_data_req.inv_raddr = s_axis_tdata;
    end

    assign w_box_req = w_busy ? w_sched_req : w_data_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_data_fire) begin
            r_p1_valid <= 1'b1;
        end else if (w_adv) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_fire) begin
            r_p1_dec   <= r_decrypt;
            r_p1_keyed <= r_keyed;
            r_p1_pos   <= r_pos;
            // identity lookup result for bytes that arrive before any key
            r_p1_idx   <= (r_decrypt == krsc_pkg::MODE_DEC) ? s_axis_tdata : w_enc_addr;
        end
    end

    // box value, or identity while unkeyed; decrypt then removes the position
    assign w_box_val  = r_p1_dec ? w_inv_rdata : w_fwd_rdata;
    assign w_lookup   = r_p1_keyed ? w_box_val : r_p1_idx;
    assign n_out_data = r_p1_dec ? (w_lookup - r_p1_pos) : w_lookup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_p1_valid) begin
            r_out_data  <= n_out_data;
            r_out_nokey <= !r_p1_keyed;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_nokey;

    krsc_key_mem #(
        .KEY_BYTES (KEY_BYTES)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_key_fire),
        .i_wr_data (s_axis_tdata),
        .i_clr     (w_done),
        .i_re      (w_key_re),
        .i_raddr   (w_key_raddr),
        .o_count   (w_key_count),
        .o_rdata   (w_key_rdata)
    );

    krsc_sched #(
        .KEY_BYTES (KEY_BYTES)
    ) u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_hold      (r_p1_valid),
        .i_key_count (w_key_count),
        .i_key_rdata (w_key_rdata),
        .i_fwd_rdata (w_fwd_rdata),
        .o_key_re    (w_key_re),
        .o_key_raddr (w_key_raddr),
        .o_req       (w_sched_req),
        .o_busy      (w_busy),
        .o_done      (w_done)
    );

    krsc_box_mem u_box_mem (
        .i_clk       (i_clk),
        .i_req       (w_box_req),
        .o_fwd_rdata (w_fwd_rdata),
        .o_inv_rdata (w_inv_rdata)
    );

`include "keyed_rotating_sbox_byte_cipher_core_assert.svh"

    // a parked data byte keeps its lookup until the output frees up
    `KRSC_ASSERT_NEXT(a_p1_parked, r_p1_valid && !w_adv, r_p1_valid && $stable(r_p1_idx), "read stage lost a data byte")

    // the schedule never reads the forward box over a parked lookup
    `KRSC_ASSERT_IMPL(a_no_read_clash, r_p1_valid && !w_adv, !w_sched_req.fwd_re, "schedule read clobbers a pending data lookup")

    // a completed schedule leaves a fresh key state behind
    `KRSC_ASSERT_NEXT(a_done_rekeys, w_done, r_keyed && (r_pos == '0) && (w_key_count == '0), "schedule end did not reset key state")

    // the final key byte always launches the sequencer
    `KRSC_ASSERT_NEXT(a_start_busy, w_start, w_busy, "key schedule did not start")

endmodule

`default_nettype wire

// File: src/krsc_key_mem.sv
// key byte store with fill counter and registered read port
// depends on krsc_pkg
`default_nettype none

module krsc_key_mem #(
    parameter int KEY_BYTES = krsc_pkg::KEY_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic [krsc_pkg::DATA_W-1:0]     i_wr_data,
    input  wire logic                            i_clr,
    input  wire logic                            i_re,
    input  wire logic [((KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1)-1:0] i_raddr,
    output logic      [krsc_pkg::KCNT_W-1:0]     o_count,
    output logic      [krsc_pkg::DATA_W-1:0]     o_rdata
);

    localparam int KA_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [krsc_pkg::DATA_W-1:0] r_mem [0:KEY_BYTES-1];
    logic [krsc_pkg::KCNT_W-1:0] r_count;
    logic                        w_room;

    // bytes past the key length are dropped
    assign w_room = r_count < krsc_pkg::KCNT_W'(KEY_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clr) begin
            r_count <= '0;
        end else if (i_wr && w_room) begin
            r_count <= r_count + krsc_pkg::KCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && w_room) begin
            r_mem[r_count[KA_W-1:0]] <= i_wr_data;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// File: src/krsc_box_mem.sv
// forward and inverse s-box memories, one read and one write port each
// depends on krsc_pkg
`default_nettype none

module krsc_box_mem (
    input  wire logic                        i_clk,
    input  wire krsc_pkg::t_box_req          i_req,
    output logic [krsc_pkg::DATA_W-1:0]      o_fwd_rdata,
    output logic [krsc_pkg::DATA_W-1:0]      o_inv_rdata
);

    logic [krsc_pkg::DATA_W-1:0] r_fwd_mem [0:krsc_pkg::BOX_DEPTH-1];
    logic [krsc_pkg::DATA_W-1:0] r_inv_mem [0:krsc_pkg::BOX_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_req.fwd_we) begin
            r_fwd_mem[i_req.fwd_waddr] <= i_req.fwd_wdata;
        end
        if (i_req.fwd_re) begin
            o_fwd_rdata <= r_fwd_mem[i_req.fwd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.inv_we) begin
            r_inv_mem[i_req.inv_waddr] <= i_req.inv_wdata;
        end
        if (i_req.inv_re) begin
            o_inv_rdata <= r_inv_mem[i_req.inv_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/krsc_sched.sv
// key schedule sequencer: identity fill, swap pass, inverse build
// depends on krsc_pkg
`default_nettype none

module krsc_sched #(
    parameter int KEY_BYTES = krsc_pkg::KEY_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic                            i_hold,
    input  wire logic [krsc_pkg::KCNT_W-1:0]     i_key_count,
    input  wire logic [krsc_pkg::DATA_W-1:0]     i_key_rdata,
    input  wire logic [krsc_pkg::DATA_W-1:0]     i_fwd_rdata,
    output logic                                 o_key_re,
    output logic [((KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1)-1:0] o_key_raddr,
    output krsc_pkg::t_box_req                   o_req,
    output logic                                 o_busy,
    output logic                                 o_done
);

    localparam int KA_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [krsc_pkg::BOX_AW-1:0] I_LAST = krsc_pkg::BOX_AW'(krsc_pkg::BOX_DEPTH - 1);

    krsc_pkg::t_sched_state r_state, n_state;
    logic [krsc_pkg::BOX_AW-1:0] r_i, n_i;
    logic [krsc_pkg::BOX_AW-1:0] r_j, n_j;
    logic [KA_W-1:0]             r_k, n_k;
    logic [krsc_pkg::DATA_W-1:0] r_si, n_si;
    logic [krsc_pkg::KCNT_W-1:0] w_len;
    logic [krsc_pkg::KCNT_W-1:0] w_k_inc;

    // an empty key acts as one byte long
    assign w_len   = (i_key_count == '0) ? krsc_pkg::KCNT_W'(1) : i_key_count;
    assign w_k_inc = krsc_pkg::KCNT_W'(r_k) + krsc_pkg::KCNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krsc_pkg::SCH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
        r_si <= n_si;
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_si     = r_si;
        o_req    = '0;
        o_key_re = 1'b0;
        o_done   = 1'b0;
        case (r_state)
            krsc_pkg::SCH_IDLE: begin
                if (i_start) begin
                    n_state = krsc_pkg::SCH_INIT;
                    n_i     = '0;
                end
            end
            krsc_pkg::SCH_INIT: begin
                o_req.fwd_we    = 1'b1;
                o_req.fwd_waddr = r_i;
                o_req.fwd_wdata = r_i;
                // wait here while a data byte still holds the read register
                if (r_i == I_LAST) begin
                    if (!i_hold) begin
                        n_state = krsc_pkg::SCH_RD_I;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                    end
                end else begin
                    n_i = r_i + krsc_pkg::BOX_AW'(1);
                end
            end
            krsc_pkg::SCH_RD_I: begin
                o_req.fwd_re    = 1'b1;
                o_req.fwd_raddr = r_i;
                o_key_re        = 1'b1;
                n_state         = krsc_pkg::SCH_RD_J;
            end
            krsc_pkg::SCH_RD_J: begin
                n_si            = i_fwd_rdata;
                n_j             = krsc_pkg::BOX_AW'(r_j + i_fwd_rdata + i_key_rdata);
                o_req.fwd_re    = 1'b1;
                o_req.fwd_raddr = n_j;
                n_state         = krsc_pkg::SCH_WR_I;
            end
            krsc_pkg::SCH_WR_I: begin
                o_req.fwd_we    = 1'b1;
                o_req.fwd_waddr = r_i;
                o_req.fwd_wdata = i_fwd_rdata;
                n_state         = krsc_pkg::SCH_WR_J;
            end
            krsc_pkg::SCH_WR_J: begin
                o_req.fwd_we    = 1'b1;
                o_req.fwd_waddr = r_j;
                o_req.fwd_wdata = r_si;
                n_i             = r_i + krsc_pkg::BOX_AW'(1);
                n_k             = (w_k_inc >= w_len) ? '0 : w_k_inc[KA_W-1:0];
                n_state         = (r_i == I_LAST) ? krsc_pkg::SCH_INV_RD : krsc_pkg::SCH_RD_I;
            end
            krsc_pkg::SCH_INV_RD: begin
                o_req.fwd_re    = 1'b1;
                o_req.fwd_raddr = r_i;
                n_state         = krsc_pkg::SCH_INV_WR;
            end
            krsc_pkg::SCH_INV_WR: begin
                o_req.inv_we    = 1'b1;
                o_req.inv_waddr = i_fwd_rdata;
                o_req.inv_wdata = r_i;
                n_i             = r_i + krsc_pkg::BOX_AW'(1);
                if (r_i == I_LAST) begin
                    n_state = krsc_pkg::SCH_IDLE;
                    o_done  = 1'b1;
                end else begin
                    n_state = krsc_pkg::SCH_INV_RD;
                end
            end
            default: begin
                n_state = krsc_pkg::SCH_IDLE;
            end
        endcase
    end

    assign o_key_raddr = r_k;
    assign o_busy      = (r_state != krsc_pkg::SCH_IDLE);

endmodule

`default_nettype wire

// File: tb/tb_keyed_rotating_sbox_byte_cipher_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the keyed rotating s-box byte cipher core
// checks every result against a behavioral cipher predictor kept in step with accepted requests
// depends on krsc_pkg and keyed_rotating_sbox_byte_cipher_core

module tb_keyed_rotating_sbox_byte_cipher_core;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIR_ROWS      = 21;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       no_key;
    } t_cipher_out;

    typedef struct packed {
        logic       is_mode;     // row writes the mode register, val[0] is the mode
        logic       act;
        logic [7:0] val;
        logic       lst;
        logic       known;       // expected result typed in below
        logic [7:0] want_byte;
        logic       want_nokey;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] value
    logic [0:0] s_axis_tuser;    // [0] action
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic [0:0] m_axis_tuser;    // [0] no_key
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    keyed_rotating_sbox_byte_cipher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cipher state as the predictor sees it
    logic [7:0] key_mem [0:255];
    logic [8:0] key_len;
    logic [7:0] fwd_box [0:255];
    logic [7:0] inv_box [0:255];
    logic [7:0] stream_pos;
    logic       keyed_flag;
    logic       dec_mode;

    t_cipher_out expected_q [$];

    int fail_count      = 0;
    int results_checked = 0;
    int data_sent       = 0;
    int key_sent        = 0;
    int schedules_run   = 0;
    int cycle_count     = 0;
    int source_idle_pct = 0;
    int sink_stall_pct;

    // long receiver hold-off, requested by toggling
    logic hold_toggle;
    logic hold_seen;
    int   hold_left;

    // directed rows: pre-key data in both modes, short keys, zero and 0xff key bytes
    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{1'b1, krsc_pkg::ACT_KEY,  {7'd0, krsc_pkg::MODE_DEC}, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h00, 1'b0, 1'b1, 8'hff, 1'b1},
        '{1'b0, krsc_pkg::ACT_DATA, 8'hff, 1'b1, 1'b1, 8'hfd, 1'b1},
        '{1'b1, krsc_pkg::ACT_KEY,  {7'd0, krsc_pkg::MODE_ENC}, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h00, 1'b0, 1'b1, 8'h03, 1'b1},
        '{1'b0, krsc_pkg::ACT_DATA, 8'hff, 1'b0, 1'b1, 8'h03, 1'b1},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h80, 1'b0, 1'b1, 8'h85, 1'b1},
        '{1'b0, krsc_pkg::ACT_KEY,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_KEY,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_KEY,  8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h5a, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'ha5, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_KEY,  8'hff, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, krsc_pkg::ACT_DATA, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    // rc4-style schedule over the stored key, then the inverse box
    task automatic schedule_boxes();
        int         len;
        int         k;
        int         i;
        logic [7:0] j;
        logic [7:0] t;
        len = (key_len == 0) ? 1 : int'(key_len);
        j = 8'd0;
        k = 0;
        for (i = 0; i < 256; i++)
            fwd_box[i] = 8'(i);
        for (i = 0; i < 256; i++) begin
            j = j + fwd_box[i] + key_mem[k];
            t = fwd_box[i];
            fwd_box[i] = fwd_box[j];
            fwd_box[j] = t;
            k++;
            if (k >= len)
                k = 0;
        end
        for (i = 0; i < 256; i++)
            inv_box[fwd_box[i]] = 8'(i);
        stream_pos = 8'd0;
        key_len = 9'd0;
        keyed_flag = 1'b1;
        schedules_run++;
    endtask

    task automatic cipher_predict(input logic act, input logic [7:0] val, input logic lst,
                                  output logic has_out, output t_cipher_out res);
        logic [7:0] idx;
        res = '0;
        has_out = 1'b0;
        if (act == krsc_pkg::ACT_KEY) begin
            // bytes past the key capacity are dropped, last still schedules
            if (key_len < krsc_pkg::KEY_BYTES_DEF) begin
                key_mem[key_len[7:0]] = val;
                key_len = key_len + 9'd1;
            end
            if (lst)
                schedule_boxes();
        end else begin
            has_out = 1'b1;
            if (dec_mode == krsc_pkg::MODE_ENC) begin
                idx = val + stream_pos;
                res.out_byte = fwd_box[idx];
            end else begin
                res.out_byte = inv_box[val] - stream_pos;
            end
            res.no_key = ~keyed_flag;
            stream_pos = stream_pos + 8'd1;
        end
    endtask

    // offer one request, with random idle cycles ahead of it
    task automatic offer(input logic act, input logic [7:0] val, input logic lst,
                         input logic known, input t_cipher_out given);
        logic        has_out;
        t_cipher_out res;
        while ($urandom_range(99) < source_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= act;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_predict(act, val, lst, has_out, res);
        if (has_out)
            expected_q.push_back(known ? given : res);
        if (act == krsc_pkg::ACT_KEY)
            key_sent++;
        else
            data_sent++;
    endtask

    task automatic send(input logic act, input logic [7:0] val, input logic lst);
        offer(act, val, lst, 1'b0, '0);
    endtask

    // mode is written only with the core drained and any schedule finished
    task automatic write_mode(input logic m);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        dec_mode = m;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int budget, input int src_idle, input int snk_stall,
                             input bit with_hold, input bit with_wrap, input bit with_ovf);
        int sent;
        int pick;
        int n;
        int i;
        source_idle_pct = src_idle;
        sink_stall_pct <= snk_stall;
        if (with_hold) begin
            // receiver holds off while data keeps coming, input must back up
            hold_toggle <= ~hold_toggle;
            for (i = 0; i < 24; i++)
                send(krsc_pkg::ACT_DATA, 8'($urandom_range(255)), 1'b0);
        end
        if (with_wrap) begin
            // fresh key then enough data for the position counter to wrap
            send(krsc_pkg::ACT_KEY, 8'($urandom_range(255)), 1'b0);
            send(krsc_pkg::ACT_KEY, 8'($urandom_range(255)), 1'b1);
            for (i = 0; i < 260; i++)
                send(krsc_pkg::ACT_DATA, 8'($urandom_range(255)), 1'b0);
        end
        if (with_ovf) begin
            // key longer than the key store, tail bytes dropped
            for (i = 0; i < 258; i++)
                send(krsc_pkg::ACT_KEY, 8'($urandom_range(255)), i == 257);
            for (i = 0; i < 8; i++)
                send(krsc_pkg::ACT_DATA, 8'($urandom_range(255)), 1'b0);
        end
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                n = $urandom_range(24, 1);
                for (i = 0; i < n; i++)
                    send(krsc_pkg::ACT_DATA, 8'($urandom_range(255)), $urandom_range(9) == 0);
            end else if (pick < 82) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
                for (i = 0; i < n; i++)
                    send(krsc_pkg::ACT_KEY, 8'($urandom_range(255)), i == n - 1);
            end else if (pick < 92) begin
                // unfinished key, later bytes extend it
                n = $urandom_range(4, 1);
                for (i = 0; i < n; i++)
                    send(krsc_pkg::ACT_KEY, 8'($urandom_range(255)), 1'b0);
            end else begin
                n = 1;
                send(krsc_pkg::ACT_DATA, 8'($urandom_range(255)), 1'b1);
            end
            sent += n;
        end
    endtask

    // receiver: check each accepted result, then pick the next ready
    always @(posedge i_clk) begin : sink
        t_cipher_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= hold_toggle;
            hold_left     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %02h/%0b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                end else begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== want.out_byte) begin
                        fail_count++;
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.out_byte, m_axis_tdata);
                    end
                    if (m_axis_tuser[0] !== want.no_key) begin
                        fail_count++;
                        $display("%0t: no_key mismatch, expected %0b, actual %0b",
                                 $time, want.no_key, m_axis_tuser[0]);
                    end
                end
            end
            if (hold_toggle != hold_seen) begin
                hold_seen     <= hold_toggle;
                hold_left     <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int          r;
        t_dir_row    row;
        int          i;
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= 8'h00;
        s_axis_tuser   <= krsc_pkg::ACT_KEY;
        s_axis_tlast   <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= krsc_pkg::MODE_ENC;
        sink_stall_pct <= 0;
        hold_toggle    <= 1'b0;
        for (i = 0; i < 256; i++) begin
            key_mem[i] = 8'h00;
            fwd_box[i] = 8'(i);
            inv_box[i] = 8'(i);
        end
        key_len    = 9'd0;
        stream_pos = 8'd0;
        keyed_flag = 1'b0;
        dec_mode   = krsc_pkg::MODE_ENC;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            row = dir_rows[r];
            if (row.is_mode)
                write_mode(row.val[0]);
            else
                offer(row.act, row.val, row.lst, row.known, {row.want_byte, row.want_nokey});
        end

        write_mode(krsc_pkg::MODE_ENC);
        run_phase(15, 0, 0, 1'b1, 1'b1, 1'b0);
        write_mode(krsc_pkg::MODE_DEC);
        run_phase(15, 67, 0, 1'b0, 1'b0, 1'b1);
        write_mode(krsc_pkg::MODE_ENC);
        run_phase(20, 0, 67, 1'b0, 1'b0, 1'b0);
        write_mode(krsc_pkg::MODE_DEC);
        run_phase(20, 8, 8, 1'b0, 1'b0, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        fail_count += expected_q.size();

        $display("ran %0d data and %0d key requests, %0d key schedules, %0d results checked",
                 data_sent, key_sent, schedules_run, results_checked);
        $display("both cipher directions, four idle/stall mixes, key overflow, position wrap");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: keyed_rotating_sbox_byte_cipher_core.f
+incdir+src
src/krsc_pkg.sv
src/krsc_key_mem.sv
src/krsc_box_mem.sv
src/krsc_sched.sv
src/keyed_rotating_sbox_byte_cipher_core.sv
tb/tb_keyed_rotating_sbox_byte_cipher_core.sv
